// ===== sv/tbc_pkg.sv =====
package tbc_pkg;

  localparam int OUT_BITS = 20;
  localparam int NUM_CH   = 2;

endpackage

// ===== sv/triangle_barycentric_coords.sv =====
// channel   | dir | handshake                         | word
// ----------+-----+-----------------------------------+------------------------------------
// point/tri | in  | in_valid_i / in_ready_o           | point_*_i, vert_a/b/c_*_i
// weights   | out | out_valid_o / out_ready_i         | bary_u/v/w_o, degenerate_o, saturated_o
//
// a word goes through 9 + OUT_BITS register stages. The pipeline takes one word per cycle
//   while the output stage is not stalled.
// the quotient comes from one bit of restoring division per stage, OUT_BITS stages in all.
// rst_ni clears only the valid bits. A stall at the output freezes every stage, and
//   in_ready_o follows out_ready_i or an empty output stage.
module triangle_barycentric_coords
  import tbc_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic signed [COORD_BITS-1:0] vert_a_x_i,
  input  logic signed [COORD_BITS-1:0] vert_a_y_i,
  input  logic signed [COORD_BITS-1:0] vert_a_z_i,
  input  logic signed [COORD_BITS-1:0] vert_b_x_i,
  input  logic signed [COORD_BITS-1:0] vert_b_y_i,
  input  logic signed [COORD_BITS-1:0] vert_b_z_i,
  input  logic signed [COORD_BITS-1:0] vert_c_x_i,
  input  logic signed [COORD_BITS-1:0] vert_c_y_i,
  input  logic signed [COORD_BITS-1:0] vert_c_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [OUT_BITS-1:0]   bary_u_o,
  output logic signed [OUT_BITS-1:0]   bary_v_o,
  output logic signed [OUT_BITS-1:0]   bary_w_o,
  output logic                         degenerate_o,
  output logic                         saturated_o
);

  localparam int DB  = COORD_BITS + 1;
  localparam int PB  = 2 * DB;
  localparam int SB  = PB + 2;
  localparam int HB  = SB / 2;
  localparam int WB  = 2 * SB + 1;
  localparam int NB  = WB + FRAC_BITS;
  localparam int QB  = OUT_BITS;
  localparam int VB  = OUT_BITS + 2;
  localparam int UB  = ((FRAC_BITS > OUT_BITS) ? FRAC_BITS : OUT_BITS) + 3;
  localparam int NST = 9 + QB;
  localparam int PA [6] = '{0, 1, 2, 1, 0, 1};
  localparam int PBI[6] = '{2, 1, 3, 4, 4, 3};
  localparam logic signed [VB-1:0] OMAX = VB'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam logic signed [VB-1:0] OMIN = -VB'(64'sd1 <<< (OUT_BITS - 1));
  localparam logic signed [UB-1:0] UMAX = UB'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
  localparam logic signed [UB-1:0] UMIN = -UB'(64'sd1 <<< (OUT_BITS - 1));
  localparam logic signed [UB-1:0] ONE  = UB'(64'sd1 <<< FRAC_BITS);

  logic           en;
  logic [NST-1:0] vld_q;

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // stage 1: edge vectors ab, ac, ap
  logic signed [COORD_BITS-1:0] pc [3];
  logic signed [COORD_BITS-1:0] ac_ [3];
  logic signed [COORD_BITS-1:0] bc [3];
  logic signed [COORD_BITS-1:0] cc [3];
  logic signed [DB-1:0]         s1_d [9];
  logic signed [DB-1:0]         s1_q [9];

  assign pc  = '{point_x_i, point_y_i, point_z_i};
  assign ac_ = '{vert_a_x_i, vert_a_y_i, vert_a_z_i};
  assign bc  = '{vert_b_x_i, vert_b_y_i, vert_b_z_i};
  assign cc  = '{vert_c_x_i, vert_c_y_i, vert_c_z_i};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_d[k]     = DB'(bc[k]) - DB'(ac_[k]);
      s1_d[3 + k] = DB'(cc[k]) - DB'(ac_[k]);
      s1_d[6 + k] = DB'(pc[k]) - DB'(ac_[k]);
    end
  end

  // stage 2: component products
  logic signed [PB-1:0] s2_d [15];
  logic signed [PB-1:0] s2_q [15];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_d[5*k]     = PB'(s1_q[k])     * PB'(s1_q[k]);
      s2_d[5*k + 1] = PB'(s1_q[k])     * PB'(s1_q[3 + k]);
      s2_d[5*k + 2] = PB'(s1_q[3 + k]) * PB'(s1_q[3 + k]);
      s2_d[5*k + 3] = PB'(s1_q[6 + k]) * PB'(s1_q[k]);
      s2_d[5*k + 4] = PB'(s1_q[6 + k]) * PB'(s1_q[3 + k]);
    end
  end

  // stage 3: dot products d00 d01 d11 d20 d21
  logic signed [SB-1:0] s3_d [5];
  logic signed [SB-1:0] s3_q [5];

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      s3_d[j] = SB'(s2_q[j]) + SB'(s2_q[5 + j]) + SB'(s2_q[10 + j]);
    end
  end

  // stage 4: partial products, second operand split in halves
  logic signed [WB-1:0] s4_lo_d [6];
  logic signed [WB-1:0] s4_hi_d [6];
  logic signed [WB-1:0] s4_lo_q [6];
  logic signed [WB-1:0] s4_hi_q [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      s4_lo_d[k] = WB'(s3_q[PA[k]]) * WB'($signed({1'b0, s3_q[PBI[k]][HB-1:0]}));
      s4_hi_d[k] = WB'(s3_q[PA[k]]) * WB'($signed(s3_q[PBI[k]][SB-1:HB]));
    end
  end

  // stage 5: den, nv, nw
  logic signed [WB-1:0] s5_f [6];
  logic signed [WB-1:0] s5_d [3];
  logic signed [WB-1:0] s5_q [3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      s5_f[k] = (s4_hi_q[k] <<< HB) + s4_lo_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      s5_d[k] = s5_f[2*k] - s5_f[2*k + 1];
    end
  end

  // stage 6: magnitudes and signs
  logic          s6_dz_q;
  logic [WB-1:0] s6_dm_q;
  logic [WB-1:0] s6_nm_q  [NUM_CH];
  logic          s6_neg_q [NUM_CH];

  // stage 7 and division stages
  logic [WB-1:0] dv_den_q [QB+1];
  logic          dv_dz_q  [QB+1];
  logic [WB-1:0] dv_rem_q [QB+1][NUM_CH];
  logic [QB-1:0] dv_nl_q  [QB+1][NUM_CH];
  logic [QB-1:0] dv_quo_q [QB+1][NUM_CH];
  logic          dv_ovf_q [QB+1][NUM_CH];
  logic          dv_neg_q [QB+1][NUM_CH];

  logic [NB-1:0] s7_n [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      s7_n[c] = {s6_nm_q[c], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      s3_q    <= s3_d;
      s4_lo_q <= s4_lo_d;
      s4_hi_q <= s4_hi_d;
      s5_q    <= s5_d;
      s6_dz_q <= (s5_q[0] == '0);
      s6_dm_q <= s5_q[0][WB-1] ? WB'(-s5_q[0]) : WB'(s5_q[0]);
      for (int c = 0; c < NUM_CH; c++) begin
        s6_nm_q[c]  <= s5_q[c+1][WB-1] ? WB'(-s5_q[c+1]) : WB'(s5_q[c+1]);
        s6_neg_q[c] <= s5_q[c+1][WB-1] ^ s5_q[0][WB-1];
      end
      dv_den_q[0] <= s6_dm_q;
      dv_dz_q[0]  <= s6_dz_q;
      for (int c = 0; c < NUM_CH; c++) begin
        dv_ovf_q[0][c] <= (s7_n[c] >> QB) >= NB'(s6_dm_q);
        dv_rem_q[0][c] <= WB'(s7_n[c] >> QB);
        dv_nl_q[0][c]  <= s7_n[c][QB-1:0];
        dv_quo_q[0][c] <= '0;
        dv_neg_q[0][c] <= s6_neg_q[c];
      end
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [WB:0] rem2 [NUM_CH];
    logic        ge   [NUM_CH];

    always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
        rem2[c] = {dv_rem_q[i][c], dv_nl_q[i][c][QB-1-i]};
        ge[c]   = rem2[c] >= {1'b0, dv_den_q[i]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_den_q[i+1] <= dv_den_q[i];
        dv_dz_q[i+1]  <= dv_dz_q[i];
        for (int c = 0; c < NUM_CH; c++) begin
          dv_rem_q[i+1][c] <= ge[c] ? WB'(rem2[c] - {1'b0, dv_den_q[i]}) : WB'(rem2[c]);
          dv_nl_q[i+1][c]  <= dv_nl_q[i][c];
          dv_quo_q[i+1][c] <= {dv_quo_q[i][c][QB-2:0], ge[c]};
          dv_ovf_q[i+1][c] <= dv_ovf_q[i][c];
          dv_neg_q[i+1][c] <= dv_neg_q[i][c];
        end
      end
    end
  end

  // sign and clamp of v and w
  logic signed [VB-1:0]       f1_sv [NUM_CH];
  logic signed [OUT_BITS-1:0] f1_d  [NUM_CH];
  logic                       f1_sd [NUM_CH];
  logic signed [OUT_BITS-1:0] f1_q  [NUM_CH];
  logic                       f1_sq [NUM_CH];
  logic                       f1_dz_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      f1_sv[c] = dv_neg_q[QB][c] ? -VB'(dv_quo_q[QB][c]) : VB'(dv_quo_q[QB][c]);
      f1_sd[c] = 1'b1;
      if (dv_ovf_q[QB][c]) begin
        f1_d[c] = dv_neg_q[QB][c] ? OUT_BITS'(OMIN) : OUT_BITS'(OMAX);
      end else if (f1_sv[c] > OMAX) begin
        f1_d[c] = OUT_BITS'(OMAX);
      end else if (f1_sv[c] < OMIN) begin
        f1_d[c] = OUT_BITS'(OMIN);
      end else begin
        f1_d[c]  = OUT_BITS'(f1_sv[c]);
        f1_sd[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q    <= f1_d;
      f1_sq   <= f1_sd;
      f1_dz_q <= dv_dz_q[QB];
    end
  end

  // u from the clamped v and w
  logic signed [UB-1:0]       u_full;
  logic signed [OUT_BITS-1:0] u_d;
  logic                       u_sat;
  logic signed [OUT_BITS-1:0] bary_u_q, bary_v_q, bary_w_q;
  logic                       degen_q, sat_q;

  always_comb begin
    u_full = ONE - UB'(f1_q[0]) - UB'(f1_q[1]);
    u_sat  = 1'b1;
    if (u_full > UMAX) begin
      u_d = OUT_BITS'(UMAX);
    end else if (u_full < UMIN) begin
      u_d = OUT_BITS'(UMIN);
    end else begin
      u_d   = OUT_BITS'(u_full);
      u_sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      degen_q  <= f1_dz_q;
      bary_u_q <= f1_dz_q ? '0 : u_d;
      bary_v_q <= f1_dz_q ? '0 : f1_q[0];
      bary_w_q <= f1_dz_q ? '0 : f1_q[1];
      sat_q    <= !f1_dz_q && (u_sat || f1_sq[0] || f1_sq[1]);
    end
  end

  assign bary_u_o     = bary_u_q;
  assign bary_v_o     = bary_v_q;
  assign bary_w_o     = bary_w_q;
  assign degenerate_o = degen_q;
  assign saturated_o  = sat_q;

endmodule

// ===== tb/sv/triangle_barycentric_coords_tb.sv =====
module triangle_barycentric_coords_tb;
  import tbc_pkg::OUT_BITS;

  localparam int CB       = 16;
  localparam int FB       = 16;
  localparam int LATENCY  = 9 + OUT_BITS;
  localparam int WD_LIMIT = 5000;

  typedef logic signed [CB-1:0] tri_t [12];
  typedef struct packed {
    logic signed [OUT_BITS-1:0] u;
    logic signed [OUT_BITS-1:0] v;
    logic signed [OUT_BITS-1:0] w;
    logic                       degen;
    logic                       sat;
  } weights_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CB-1:0] pt_q [12];
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OUT_BITS-1:0] bary_u_o, bary_v_o, bary_w_o;
  logic degenerate_o, saturated_o;

  weights_t weights_q [$];
  int n_err = 0, n_in = 0, n_out = 0, n_degen = 0, n_sat = 0;
  int hold_req = 0, idle_cycles = 0;
  int burst_left = 0;
  logic rdy_n = 1'b0;

  initial begin
    for (int i = 0; i < 12; i++) pt_q[i] = '0;
  end

  always #5 clk_i = ~clk_i;

  triangle_barycentric_coords i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .point_x_i (pt_q[0]), .point_y_i (pt_q[1]), .point_z_i (pt_q[2]),
    .vert_a_x_i(pt_q[3]), .vert_a_y_i(pt_q[4]), .vert_a_z_i(pt_q[5]),
    .vert_b_x_i(pt_q[6]), .vert_b_y_i(pt_q[7]), .vert_b_z_i(pt_q[8]),
    .vert_c_x_i(pt_q[9]), .vert_c_y_i(pt_q[10]), .vert_c_z_i(pt_q[11]),
    .out_valid_o, .out_ready_i, .bary_u_o, .bary_v_o, .bary_w_o,
    .degenerate_o, .saturated_o
  );

  function automatic logic signed [127:0] clamp_weight(logic signed [127:0] x, inout bit sat);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (OUT_BITS - 1)) - 1;
    lo = -(128'sd1 <<< (OUT_BITS - 1));
    if (x > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (x < lo) begin
      sat = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic weights_t solve_weights(tri_t c);
    longint ab [3], ac [3], ap [3];
    logic signed [127:0] d00, d01, d11, d20, d21, den, nv, nw, qv, qw, qu;
    bit sat;
    weights_t r;
    d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0; sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = longint'(c[6+i]) - longint'(c[3+i]);
      ac[i] = longint'(c[9+i]) - longint'(c[3+i]);
      ap[i] = longint'(c[i]) - longint'(c[3+i]);
      d00 += ab[i] * ab[i];
      d01 += ab[i] * ac[i];
      d11 += ac[i] * ac[i];
      d20 += ap[i] * ab[i];
      d21 += ap[i] * ac[i];
    end
    den = d00 * d11 - d01 * d01;
    r = '0;
    if (den == 0) begin
      r.degen = 1'b1;
      return r;
    end
    nv = d11 * d20 - d01 * d21;
    nw = d00 * d21 - d01 * d20;
    qv = clamp_weight((nv <<< FB) / den, sat);
    qw = clamp_weight((nw <<< FB) / den, sat);
    qu = clamp_weight((128'sd1 <<< FB) - qv - qw, sat);
    r.u = qu[OUT_BITS-1:0];
    r.v = qv[OUT_BITS-1:0];
    r.w = qw[OUT_BITS-1:0];
    r.sat = sat;
    return r;
  endfunction

  always @(negedge clk_i) rdy_n <= in_ready_o;

  // output checker
  always @(posedge clk_i) begin
    weights_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out++;
      if (weights_q.size() == 0) begin
        $display("%0t: unexpected word u=%0d v=%0d w=%0d", $time, bary_u_o, bary_v_o, bary_w_o);
        n_err++;
      end else begin
        exp_w = weights_q.pop_front();
        if (exp_w.degen) n_degen++;
        if (exp_w.sat) n_sat++;
        if (bary_u_o !== exp_w.u) begin
          $display("%0t: u exp %0d got %0d", $time, exp_w.u, bary_u_o); n_err++;
        end
        if (bary_v_o !== exp_w.v) begin
          $display("%0t: v exp %0d got %0d", $time, exp_w.v, bary_v_o); n_err++;
        end
        if (bary_w_o !== exp_w.w) begin
          $display("%0t: w exp %0d got %0d", $time, exp_w.w, bary_w_o); n_err++;
        end
        if (degenerate_o !== exp_w.degen) begin
          $display("%0t: degenerate exp %0b got %0b", $time, exp_w.degen, degenerate_o); n_err++;
        end
        if (saturated_o !== exp_w.sat) begin
          $display("%0t: saturated exp %0b got %0b", $time, exp_w.sat, saturated_o); n_err++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int n, mode;
    mode = 0;
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        repeat (n) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      if ($urandom_range(63) == 0) mode = $urandom_range(3);
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(9) > 2);
        2: out_ready_i <= ($urandom_range(9) > 6);
        default: out_ready_i <= ~out_ready_i;
      endcase
      @(posedge clk_i);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_word(tri_t c);
    int gap;
    in_valid_i <= 1'b1;
    for (int i = 0; i < 12; i++) pt_q[i] <= c[i];
    do @(posedge clk_i); while (!rdy_n);
    weights_q.push_back(solve_weights(c));
    n_in++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24);
      gap = $urandom_range(6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic tri_t rand_tri(int span);
    tri_t c;
    int base;
    for (int i = 0; i < 12; i++) begin
      if (span == 0) c[i] = CB'($urandom);
      else begin
        base = (i < 3) ? 0 : 0;
        c[i] = CB'($urandom_range(2 * span) - span + base);
      end
    end
    return c;
  endfunction

  function automatic tri_t make_tri(int p0, int p1, int p2, int a0, int a1, int a2,
                                    int b0, int b1, int b2, int c0, int c1, int c2);
    tri_t c;
    c = '{CB'(p0), CB'(p1), CB'(p2), CB'(a0), CB'(a1), CB'(a2),
          CB'(b0), CB'(b1), CB'(b2), CB'(c0), CB'(c1), CB'(c2)};
    return c;
  endfunction

  task automatic drain;
    in_valid_i <= 1'b0;
    while (weights_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed;
    send_word(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_tri(5, 5, 5, 0, 0, 0, 1, 1, 1, 2, 2, 2));
    send_word(make_tri(0, 0, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0));
    send_word(make_tri(10, 0, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0));
    send_word(make_tri(0, 10, 0, 0, 0, 0, 10, 0, 0, 0, 10, 0));
    send_word(make_tri(3, 3, 7, 0, 0, 0, 9, 0, 0, 0, 9, 0));
    send_word(make_tri(-9, -9, 0, 1, 1, 0, 4, 1, 0, 1, 4, 0));
    send_word(make_tri(32767, 32767, 32767, -32768, -32768, -32768, -32767, -32768, -32768,
                       -32768, -32767, -32768));
    send_word(make_tri(-32768, 32767, -32768, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_word(make_tri(32767, -32768, 32767, 0, 0, 0, 0, 1, 0, 1, 0, 0));
    send_word(make_tri(0, 0, 0, -32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 32767));
    send_word(make_tri(32767, 32767, 32767, 32767, 32767, 32767, -32768, 32767, 32767,
                       32767, -32768, -32768));
    send_word(make_tri(-32768, -32768, -32768, 32767, 0, 0, -32768, 32767, 0, 0, -32768, 32767));
    send_word(make_tri(7, 7, 7, 1, 1, 1, 1, 1, 1, 4, 5, 6));
    send_word(make_tri(100, -100, 50, 0, 0, 0, 3, 0, 0, 0, 3, 0));
    send_word(make_tri(-100, 100, 0, 0, 0, 0, 3, 0, 0, 0, 3, 0));
    send_word(make_tri(20, 20, 0, 0, 0, 0, 1, 2, 0, 2, 1, 0));
    drain();
  endtask

  task automatic test_random(int n);
    tri_t c;
    int sel, k;
    repeat (n) begin
      sel = $urandom_range(9);
      if (sel < 4) c = rand_tri(0);
      else if (sel < 7) c = rand_tri(200);
      else if (sel < 8) c = rand_tri(4);
      else begin
        c = rand_tri(0);
        k = $urandom_range(1);
        for (int i = 0; i < 3; i++) begin
          if (k == 0) c[6+i] = c[3+i];
          else c[9+i] = CB'(2 * int'(c[6+i]) - int'(c[3+i]));
        end
      end
      send_word(c);
    end
  endtask

  task automatic test_backpressure;
    hold_req = 300;
    test_random(80);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(220);
    test_backpressure();
    test_random(250);
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("%0d words in, %0d out: %0d degenerate, %0d saturated, stalls and long hold-off",
             n_in, n_out, n_degen, n_sat);
    if (n_err == 0 && weights_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
